>>> rtl/core/sws_pkg.sv
// Package for the sliding window sender core.
// Holds the field widths, event and status codes and controller states.
// No dependencies.
`default_nettype none

package sws_pkg;

  localparam int unsigned SEQ_W      = 16;
  localparam int unsigned WIN_W      = 9;
  localparam int unsigned PKT_W      = 16;
  localparam int unsigned OP_W       = 3;
  localparam int unsigned STAT_W     = 2;
  localparam int unsigned RETRY_W    = 4;
  localparam int unsigned SLOT_OUT_W = 8;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned MOD_STEP_W = 4;

  localparam int unsigned MAX_WINDOW_DEF  = 256;
  localparam int unsigned MAX_RETRIES_DEF = 10;
  localparam int unsigned INIT_SEQ_DEF    = 1;

  localparam logic [SEQ_W-1:0] LAST_CAP = 16'hFFFE;

  typedef enum logic [OP_W-1:0] {
    OP_START   = 3'd0,
    OP_SEND    = 3'd1,
    OP_ACK     = 3'd2,
    OP_NAK     = 3'd3,
    OP_CORRUPT = 3'd4,
    OP_TIMEOUT = 3'd5
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_RUN    = 2'd0,
    STAT_DONE   = 2'd1,
    STAT_FAILED = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_SIZE  = 1'b0,
    CFG_PACKET_COUNT = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_RD,
    ST_CMP,
    ST_RESP
  } state_e;

endpackage

`default_nettype wire

>>> rtl/core/sws_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module sws_ram #(
  parameter int unsigned WIDTH = 17,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/core/sws_mod.sv
// Iterative remainder unit: restoring division, MOD_STEP_W quotient bits per cycle.
// Depends on sws_pkg for the bits retired per cycle.
`default_nettype none

module sws_mod #(
  parameter int unsigned NUM_W = 16,
  parameter int unsigned DEN_W = 9
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic                  done_o,
  output logic      [DEN_W-1:0] rem_o
);

  localparam int unsigned STEP_W = sws_pkg::MOD_STEP_W;
  localparam int unsigned STEPS  = NUM_W / STEP_W;
  localparam int unsigned CNT_W  = $clog2(STEPS + 1);

  logic [NUM_W-1:0] num_q, num_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             done_q, done_d;

  always_comb begin
    logic [NUM_W-1:0] n;
    logic [DEN_W-1:0] r;
    logic [DEN_W:0]   r_sh;
    n      = num_q;
    r      = rem_q;
    r_sh   = '0;
    num_d  = num_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      num_d = num_i;
      rem_d = '0;
      cnt_d = CNT_W'(STEPS);
    end else if (cnt_q != '0) begin
      for (int k = 0; k < STEP_W; k++) begin
        r_sh = {r, n[NUM_W-1]};
        n    = {n[NUM_W-2:0], 1'b0};
        if (r_sh >= {1'b0, den_i}) begin
          r_sh = r_sh - {1'b0, den_i};
        end
        r = r_sh[DEN_W-1:0];
      end
      num_d  = n;
      rem_d  = r;
      cnt_d  = cnt_q - CNT_W'(1);
      done_d = (cnt_q == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

>>> rtl/core/sliding_window_sender_core.sv
// Top level of the go-back-N sliding window sender core.
// Depends on sws_pkg, sws_mod and sws_ram.
`default_nettype none

// One event item is taken at a time. A send opportunity that sends first works out the
// remainder of the sequence by the window (four quotient bits a cycle, then a flag for
// the end), then reads the slot tag memory, then compares and writes the tag back, and
// then goes to the response state. A start, ack, nak, corrupt reply, timeout, send
// opportunity that finds the window closed or any other event item goes straight to the
// response state. That state loads the result into the output register once the
// receiver has taken any earlier result held there. The next event item can be accepted
// in the same cycle as the result is offered. After reset, and after every start item,
// the tag memory is swept clear at one entry a cycle over all MAX_WINDOW entries,
// during which no event item is accepted; configuration writes are taken at all times
// and must come only while the core is idle.

module sliding_window_sender_core #(
  parameter int unsigned MAX_WINDOW  = sws_pkg::MAX_WINDOW_DEF,
  parameter int unsigned MAX_RETRIES = sws_pkg::MAX_RETRIES_DEF,
  parameter int unsigned INIT_SEQ    = sws_pkg::INIT_SEQ_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Event items.
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire logic [sws_pkg::SEQ_W-1:0]       s_axis_tdata,  // [15:0] reply_seq
  input  wire logic [sws_pkg::OP_W-1:0]        s_axis_tuser,  // [2:0] op
  // Result items.
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  output logic      [31:0]                     m_axis_tdata,  // [15:0] send_seq,
                                                              // [23:16] buffer_slot,
                                                              // [24] fetch_new, rest zero
  output logic      [2:0]                      m_axis_tuser,  // [0] send_valid,
                                                              // [2:1] status
  // Configuration writes.
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [sws_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [sws_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned SEQ_W   = sws_pkg::SEQ_W;
  localparam int unsigned WIN_W   = sws_pkg::WIN_W;
  localparam int unsigned PKT_W   = sws_pkg::PKT_W;
  localparam int unsigned RETRY_W = sws_pkg::RETRY_W;
  localparam int unsigned SLOT_W  = sws_pkg::SLOT_OUT_W;
  localparam int unsigned AW      = $clog2(MAX_WINDOW);
  localparam int unsigned TAG_W   = SEQ_W + 1;
  localparam int unsigned WIN_CAP = (MAX_WINDOW > (2 ** WIN_W) - 1) ?
                                    (2 ** WIN_W) - 1 : MAX_WINDOW;

  sws_pkg::state_e  st_q, st_d;
  sws_pkg::status_e status_q, status_d, status_fin;

  logic [WIN_W-1:0]   win_q, win_d;
  logic [PKT_W-1:0]   pkt_q, pkt_d;
  logic [SEQ_W-1:0]   next_q, next_d;
  logic [SEQ_W-1:0]   acked_q, acked_d;
  logic [SEQ_W-1:0]   limit_q, limit_d;
  logic [RETRY_W-1:0] retry_q, retry_d;
  logic [SEQ_W-1:0]   seq_q, seq_d;
  logic [AW-1:0]      clr_addr_q, clr_addr_d;
  logic               upd_lim_q, upd_lim_d;
  logic               clr_pend_q, clr_pend_d;

  logic               res_valid_q, res_valid_d;
  logic [SEQ_W-1:0]   res_seq_q, res_seq_d;
  logic [SLOT_W-1:0]  res_slot_q, res_slot_d;
  logic               res_fetch_q, res_fetch_d;

  logic               out_valid_q, out_valid_d;
  logic [31:0]        out_data_q, out_data_d;
  logic [2:0]         out_user_q, out_user_d;

  logic [WIN_W-1:0]   eff_win;
  logic [SEQ_W:0]     last_sum;
  logic [SEQ_W-1:0]   end_seq;
  logic [SEQ_W:0]     lim_sum;
  logic [SEQ_W-1:0]   acked_inc;

  logic               mod_start;
  logic               mod_done;
  logic [WIN_W-1:0]   mod_rem;
  logic [AW+WIN_W-1:0] slot_ext;
  logic [AW-1:0]      slot_addr;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [TAG_W-1:0]   ram_wdata;
  logic [TAG_W-1:0]   ram_rdata;
  logic               tag_hit;

  logic               in_acc;
  sws_pkg::op_e       in_op;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    win_d = win_q;
    pkt_d = pkt_q;
    if (cfg_valid_i) begin
      unique case (sws_pkg::cfg_idx_e'(cfg_index_i))
        sws_pkg::CFG_WINDOW_SIZE:  win_d = cfg_data_i[WIN_W-1:0];
        sws_pkg::CFG_PACKET_COUNT: pkt_d = cfg_data_i[PKT_W-1:0];
        default: ;
      endcase
    end
  end

  assign eff_win = (win_q == '0) ? WIN_W'(1) :
                   (win_q > WIN_W'(WIN_CAP)) ? WIN_W'(WIN_CAP) : win_q;

  assign last_sum = {1'b0, pkt_q} + (SEQ_W + 1)'(INIT_SEQ);
  assign end_seq  = (last_sum > {1'b0, sws_pkg::LAST_CAP}) ? sws_pkg::LAST_CAP :
                    last_sum[SEQ_W-1:0];

  assign lim_sum   = {1'b0, acked_q} + {{(SEQ_W + 1 - WIN_W){1'b0}}, eff_win};
  assign acked_inc = (acked_q == '1) ? acked_q : acked_q + SEQ_W'(1);

  assign status_fin = (status_q == sws_pkg::STAT_RUN && next_q > end_seq &&
                       acked_q >= end_seq) ? sws_pkg::STAT_DONE : status_q;

  assign slot_ext  = {{AW{1'b0}}, mod_rem};
  assign slot_addr = slot_ext[AW-1:0];
  assign tag_hit   = ram_rdata[SEQ_W] && (ram_rdata[SEQ_W-1:0] == seq_q);

  assign s_axis_tready = (st_q == sws_pkg::ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_op         = sws_pkg::op_e'(s_axis_tuser);

  always_comb begin
    st_d        = st_q;
    status_d    = status_q;
    next_d      = next_q;
    acked_d     = acked_q;
    limit_d     = limit_q;
    retry_d     = retry_q;
    seq_d       = seq_q;
    clr_addr_d  = clr_addr_q;
    upd_lim_d   = upd_lim_q;
    clr_pend_d  = clr_pend_q;
    res_valid_d = res_valid_q;
    res_seq_d   = res_seq_q;
    res_slot_d  = res_slot_q;
    res_fetch_d = res_fetch_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    out_user_d  = out_user_q;
    mod_start   = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = slot_addr;
    ram_wdata   = {1'b1, seq_q};

    unique case (st_q)
      sws_pkg::ST_CLEAR: begin
        ram_we     = 1'b1;
        ram_waddr  = clr_addr_q;
        ram_wdata  = '0;
        clr_addr_d = clr_addr_q + AW'(1);
        if (clr_addr_q == AW'(MAX_WINDOW - 1)) begin
          clr_addr_d = '0;
          st_d       = sws_pkg::ST_IDLE;
        end
      end
      sws_pkg::ST_IDLE: begin
        if (in_acc) begin
          res_valid_d = 1'b0;
          res_seq_d   = '0;
          res_slot_d  = '0;
          res_fetch_d = 1'b0;
          st_d        = sws_pkg::ST_RESP;
          if (in_op == sws_pkg::OP_START) begin
            acked_d    = SEQ_W'(INIT_SEQ);
            next_d     = SEQ_W'(INIT_SEQ + 1);
            retry_d    = '0;
            status_d   = sws_pkg::STAT_RUN;
            upd_lim_d  = 1'b1;
            clr_pend_d = 1'b1;
          end else if (status_q == sws_pkg::STAT_RUN) begin
            unique case (in_op)
              sws_pkg::OP_SEND: begin
                if (next_q <= limit_q) begin
                  seq_d     = next_q;
                  mod_start = 1'b1;
                  st_d      = sws_pkg::ST_MOD;
                end
              end
              sws_pkg::OP_ACK: begin
                if (s_axis_tdata > acked_q) begin
                  acked_d = s_axis_tdata;
                end
                upd_lim_d = 1'b1;
                retry_d   = '0;
              end
              sws_pkg::OP_NAK: begin
                next_d  = s_axis_tdata;
                retry_d = '0;
              end
              sws_pkg::OP_CORRUPT: begin
                retry_d = '0;
              end
              sws_pkg::OP_TIMEOUT: begin
                if (retry_q < RETRY_W'(MAX_RETRIES)) begin
                  retry_d = retry_q + RETRY_W'(1);
                  next_d  = acked_inc;
                end else begin
                  status_d = sws_pkg::STAT_FAILED;
                end
              end
              default: ;
            endcase
          end
        end
      end
      sws_pkg::ST_MOD: begin
        if (mod_done) begin
          st_d = sws_pkg::ST_RD;
        end
      end
      sws_pkg::ST_RD: begin
        st_d = sws_pkg::ST_CMP;
      end
      sws_pkg::ST_CMP: begin
        ram_we      = 1'b1;
        res_valid_d = 1'b1;
        res_seq_d   = seq_q;
        res_slot_d  = mod_rem[SLOT_W-1:0];
        res_fetch_d = !tag_hit;
        next_d      = seq_q + SEQ_W'(1);
        st_d        = sws_pkg::ST_RESP;
      end
      sws_pkg::ST_RESP: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = {7'b0, res_fetch_q, res_slot_q, res_seq_q};
          out_user_d  = {status_fin, res_valid_q};
          status_d    = status_fin;
          if (upd_lim_q) begin
            limit_d = (lim_sum < {1'b0, end_seq}) ? lim_sum[SEQ_W-1:0] : end_seq;
          end
          upd_lim_d  = 1'b0;
          clr_pend_d = 1'b0;
          st_d       = clr_pend_q ? sws_pkg::ST_CLEAR : sws_pkg::ST_IDLE;
        end
      end
      default: st_d = sws_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= sws_pkg::ST_CLEAR;
      status_q    <= sws_pkg::STAT_RUN;
      win_q       <= WIN_W'(1);
      pkt_q       <= '0;
      next_q      <= SEQ_W'(INIT_SEQ + 1);
      acked_q     <= SEQ_W'(INIT_SEQ);
      limit_q     <= SEQ_W'(INIT_SEQ);
      retry_q     <= '0;
      clr_addr_q  <= '0;
      upd_lim_q   <= 1'b0;
      clr_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      status_q    <= status_d;
      win_q       <= win_d;
      pkt_q       <= pkt_d;
      next_q      <= next_d;
      acked_q     <= acked_d;
      limit_q     <= limit_d;
      retry_q     <= retry_d;
      clr_addr_q  <= clr_addr_d;
      upd_lim_q   <= upd_lim_d;
      clr_pend_q  <= clr_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    seq_q       <= seq_d;
    res_valid_q <= res_valid_d;
    res_seq_q   <= res_seq_d;
    res_slot_q  <= res_slot_d;
    res_fetch_q <= res_fetch_d;
    out_data_q  <= out_data_d;
    out_user_q  <= out_user_d;
  end

  sws_mod #(
    .NUM_W (SEQ_W),
    .DEN_W (WIN_W)
  ) u_sws_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .num_i   (seq_d),
    .den_i   (eff_win),
    .done_o  (mod_done),
    .rem_o   (mod_rem)
  );

  sws_ram #(
    .WIDTH (TAG_W),
    .DEPTH (MAX_WINDOW)
  ) u_sws_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (slot_addr),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

`default_nettype wire

>>> verif/sws_checker.sv
`timescale 1ns / 100ps
// Checker for the sliding window sender core: watches the event, result and register channels,
// predicts every result from its own copy of the sender state and compares field by field.
// Depends on sws_pkg.

module sws_checker
  import sws_pkg::*;
#(
  parameter int unsigned MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int unsigned MAX_RETRIES = MAX_RETRIES_DEF,
  parameter int unsigned INIT_SEQ    = INIT_SEQ_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  ev_valid_i,
  input  logic                  ev_ready_i,
  input  logic [SEQ_W-1:0]      ev_data_i,   // [15:0] reply_seq
  input  logic [OP_W-1:0]       ev_user_i,   // [2:0] op
  input  logic                  res_valid_i,
  input  logic                  res_ready_i,
  input  logic [31:0]           res_data_i,  // [15:0] send_seq, [23:16] buffer_slot,
                                             // [24] fetch_new, rest zero
  input  logic [2:0]            res_user_i,  // [0] send_valid, [2:1] status
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    checked_o
);

  typedef struct packed {
    logic                  sent;
    logic [SEQ_W-1:0]      seq;
    logic [SLOT_OUT_W-1:0] slot;
    logic                  fetch;
    status_e               status;
  } reply_t;

  logic [WIN_W-1:0] window_reg;
  logic [PKT_W-1:0] count_reg;
  int unsigned      next_seq;
  int unsigned      acked_seq;
  int unsigned      limit_seq;
  int unsigned      retries;
  bit               slot_full [MAX_WINDOW];
  logic [SEQ_W-1:0] slot_seq [MAX_WINDOW];
  status_e          run_state;
  reply_t           reply_q [$];
  int               checked_n;

  function automatic int unsigned window_in_use();
    if (window_reg == '0) return 1;
    if (window_reg > MAX_WINDOW) return MAX_WINDOW;
    return window_reg;
  endfunction

  function automatic int unsigned final_seq();
    int unsigned last;
    last = count_reg + INIT_SEQ;
    return (last > LAST_CAP) ? LAST_CAP : last;
  endfunction

  function automatic void open_window();
    int unsigned lim;
    lim = acked_seq + window_in_use();
    limit_seq = (lim < final_seq()) ? lim : final_seq();
  endfunction

  function automatic void clear_transfer();
    acked_seq = INIT_SEQ;
    next_seq  = INIT_SEQ + 1;
    retries   = 0;
    run_state = STAT_RUN;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      slot_full[i] = 1'b0;
      slot_seq[i]  = '0;
    end
  endfunction

  function automatic reply_t sender_reply(logic [OP_W-1:0] op, logic [SEQ_W-1:0] rseq);
    reply_t      r;
    int unsigned slot;
    r = '0;
    if (op == OP_START) begin
      clear_transfer();
      open_window();
    end else if (run_state == STAT_RUN) begin
      case (op)
        OP_SEND: begin
          if (next_seq <= limit_seq) begin
            slot    = next_seq % window_in_use();
            r.sent  = 1'b1;
            r.seq   = next_seq[SEQ_W-1:0];
            r.slot  = slot[SLOT_OUT_W-1:0];
            r.fetch = !(slot_full[slot] && slot_seq[slot] == r.seq);
            slot_full[slot] = 1'b1;
            slot_seq[slot]  = r.seq;
            next_seq = next_seq + 1;
          end
        end
        OP_ACK: begin
          if (rseq > acked_seq) acked_seq = rseq;
          open_window();
          retries = 0;
        end
        OP_NAK: begin
          next_seq = rseq;
          retries  = 0;
        end
        OP_CORRUPT: begin
          retries = 0;
        end
        OP_TIMEOUT: begin
          if (retries < MAX_RETRIES) begin
            retries++;
            next_seq = (acked_seq >= 32'hFFFF) ? 32'hFFFF : acked_seq + 1;
          end else begin
            run_state = STAT_FAILED;
          end
        end
        default: begin
        end
      endcase
    end
    if (run_state == STAT_RUN && next_seq > final_seq() && acked_seq >= final_seq()) begin
      run_state = STAT_DONE;
    end
    r.status = run_state;
    return r;
  endfunction

  function automatic int field_diff(string name, int unsigned want, int unsigned got);
    if (want == got) return 0;
    $display("%0t: result %0d, %s expected 0x%0h, actual 0x%0h", $time, checked_n, name,
             want, got);
    return 1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    reply_t want;
    int     errs;
    if (!rst_ni) begin
      window_reg = WIN_W'(1);
      count_reg  = '0;
      clear_transfer();
      limit_seq = INIT_SEQ;
      reply_q.delete();
      checked_n = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
    end else begin
      errs = 0;
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_WINDOW_SIZE) window_reg = cfg_data_i[WIN_W-1:0];
        else count_reg = cfg_data_i[PKT_W-1:0];
      end
      if (res_valid_i && res_ready_i) begin
        if (reply_q.size() == 0) begin
          $display("%0t: result with none expected, actual data 0x%0h user 0x%0h", $time,
                   res_data_i, res_user_i);
          errs++;
        end else begin
          want = reply_q.pop_front();
          errs += field_diff("send_valid", want.sent, res_user_i[0]);
          errs += field_diff("send_seq", want.seq, res_data_i[15:0]);
          errs += field_diff("buffer_slot", want.slot, res_data_i[23:16]);
          errs += field_diff("fetch_new", want.fetch, res_data_i[24]);
          errs += field_diff("padding", 0, res_data_i[31:25]);
          errs += field_diff("status", want.status, res_user_i[2:1]);
          checked_n++;
        end
      end
      if (ev_valid_i && ev_ready_i) reply_q.push_back(sender_reply(ev_user_i, ev_data_i));
      fail_count_o <= fail_count_o + errs;
      pending_o    <= reply_q.size();
      checked_o    <= checked_n;
    end
  end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// Top of the sliding window sender testbench: clock, reset, event and register stimulus,
// a randomly stalling result sink and the verdict. Depends on sws_pkg, the core and sws_checker.

module tb_top;
  import sws_pkg::*;

  localparam int unsigned EVENT_TARGET = 650;
  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned TAIL_CYCLES  = 20;
  localparam int unsigned MAX_GAP      = 6;

  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  ev_valid  = 1'b0;
  logic                  ev_ready;
  logic [SEQ_W-1:0]      ev_seq    = '0;
  logic [OP_W-1:0]       ev_op     = '0;
  logic                  res_valid;
  logic                  res_ready = 1'b0;
  logic [31:0]           res_data;
  logic [2:0]            res_user;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int fail_count;
  int pending;
  int checked;
  int cycle_count = 0;
  int issued      = 0;
  int phases      = 0;
  bit hold_req    = 1'b0;
  bit eager_send  = 1'b0;

  sliding_window_sender_core dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (ev_valid),
    .s_axis_tready (ev_ready),
    .s_axis_tdata  (ev_seq),
    .s_axis_tuser  (ev_op),
    .m_axis_tvalid (res_valid),
    .m_axis_tready (res_ready),
    .m_axis_tdata  (res_data),
    .m_axis_tuser  (res_user),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  sws_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .ev_valid_i   (ev_valid),
    .ev_ready_i   (ev_ready),
    .ev_data_i    (ev_seq),
    .ev_user_i    (ev_op),
    .res_valid_i  (res_valid),
    .res_ready_i  (res_ready),
    .res_data_i   (res_data),
    .res_user_i   (res_user),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("simulation failed");
    $finish;
  end

  function automatic logic [SEQ_W-1:0] sat16(int unsigned v);
    return (v > 32'hFFFF) ? 16'hFFFF : v[SEQ_W-1:0];
  endfunction

  task automatic post_event(logic [OP_W-1:0] op, logic [SEQ_W-1:0] seq);
    int unsigned gap;
    gap = eager_send ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      ev_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    ev_valid <= 1'b1;
    ev_op    <= op;
    ev_seq   <= seq;
    do @(posedge clk); while (!ev_ready);
    issued++;
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_setup(logic [CFG_DATA_W-1:0] win_word, logic [CFG_DATA_W-1:0] count);
    write_reg(CFG_WINDOW_SIZE, win_word);
    write_reg(CFG_PACKET_COUNT, count);
    phases++;
  endtask

  task automatic drain_results();
    ev_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    while (!ev_ready) @(posedge clk);
  endtask

  task automatic run_transfer(int unsigned n_events, bit lossy);
    int unsigned acked_guess;
    int unsigned sent_guess;
    int unsigned roll;
    int unsigned advance;
    acked_guess = INIT_SEQ_DEF;
    sent_guess  = INIT_SEQ_DEF;
    post_event(OP_START, SEQ_W'($urandom_range(0, 16'hFFFF)));
    repeat (n_events) begin
      roll = $urandom_range(0, 99);
      if (lossy && roll < 10) begin
        repeat ($urandom_range(5, 12)) begin
          post_event(OP_TIMEOUT, SEQ_W'($urandom_range(0, 16'hFFFF)));
        end
      end else if (roll < 45) begin
        post_event(OP_SEND, SEQ_W'($urandom_range(0, 16'hFFFF)));
        sent_guess++;
      end else if (roll < 70) begin
        advance = $urandom_range(0, 2);
        if (acked_guess + advance <= sent_guess) acked_guess += advance;
        post_event(OP_ACK, sat16(acked_guess));
      end else if (roll < 78) begin
        post_event(OP_NAK, sat16(acked_guess + $urandom_range(1, 3)));
      end else if (roll < 84) begin
        post_event(OP_CORRUPT, SEQ_W'($urandom_range(0, 16'hFFFF)));
      end else if (roll < 92) begin
        post_event(OP_TIMEOUT, SEQ_W'($urandom_range(0, 16'hFFFF)));
      end else begin
        case ($urandom_range(0, 9))
          0, 1:    post_event(OP_SPARE_LO, SEQ_W'($urandom_range(0, 16'hFFFF)));
          2, 3:    post_event(OP_SPARE_HI, SEQ_W'($urandom_range(0, 16'hFFFF)));
          4, 5, 6: post_event(OP_ACK, SEQ_W'($urandom_range(0, 16'hFFFF)));
          7, 8:    post_event(OP_NAK, SEQ_W'($urandom_range(0, 16'hFFFF)));
          default: post_event(OP_START, SEQ_W'($urandom_range(0, 16'hFFFF)));
        endcase
      end
    end
  endtask

  initial begin : result_sink
    int unsigned stall;
    int unsigned left_in_mode;
    bit          eager_recv;
    bit          held;
    left_in_mode = 0;
    eager_recv   = 1'b0;
    held         = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (left_in_mode == 0) begin
        eager_recv   = ($urandom_range(0, 3) == 0);
        left_in_mode = $urandom_range(10, 40);
      end
      left_in_mode--;
      if (hold_req && !held) begin
        stall = HOLD_CYCLES;
        held  = 1'b1;
      end else begin
        stall = eager_recv ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (stall > 0) begin
        res_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ready <= 1'b1;
      do @(posedge clk); while (!res_valid);
    end
  end

  initial begin : stimulus
    int unsigned win;
    int unsigned count;
    int          directed;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Before any start the transfer already counts as complete.
    post_event(OP_SEND, 16'h0000);
    drain_results();

    // A window register of zero behaves as one.
    write_setup(16'h0000, 16'd3);
    post_event(OP_START, 16'h0000);
    post_event(OP_SEND, 16'h0000);
    post_event(OP_SEND, 16'h0000);
    post_event(OP_ACK, 16'd2);
    post_event(OP_SEND, 16'h0000);
    post_event(OP_SPARE_LO, 16'hFFFF);
    post_event(OP_NAK, 16'd2);
    post_event(OP_SEND, 16'h0000);
    post_event(OP_TIMEOUT, 16'h0000);
    post_event(OP_ACK, 16'd4);
    post_event(OP_SEND, 16'h0000);
    post_event(OP_SEND, 16'h0000);
    post_event(OP_SPARE_HI, 16'h0000);
    drain_results();

    // Oversized window, saturated last sequence and the timeout rewind limit.
    write_setup(16'hFFFF, 16'hFFFF);
    post_event(OP_START, 16'hFFFF);
    post_event(OP_NAK, 16'hFFFF);
    post_event(OP_SEND, 16'h0000);
    post_event(OP_NAK, 16'h0000);
    post_event(OP_SEND, 16'hFFFF);
    post_event(OP_ACK, 16'hFFFF);
    post_event(OP_TIMEOUT, 16'h0000);
    drain_results();

    directed = issued;
    while (issued < directed + EVENT_TARGET) begin
      case ($urandom_range(0, 9))
        0:       win = 0;
        1:       win = MAX_WINDOW_DEF;
        2:       win = $urandom_range(MAX_WINDOW_DEF + 1, 511);
        3, 4, 5: win = $urandom_range(1, 4);
        6, 7:    win = $urandom_range(5, 16);
        default: win = $urandom_range(17, MAX_WINDOW_DEF - 1);
      endcase
      case ($urandom_range(0, 9))
        0:       count = 0;
        1:       count = $urandom_range(60000, 16'hFFFF);
        default: count = $urandom_range(1, 24);
      endcase
      write_setup({7'($urandom_range(0, 127)), 9'(win)}, 16'(count));
      eager_send = ($urandom_range(0, 3) == 0);
      if (phases == 6) hold_req = 1'b1;
      run_transfer($urandom_range(20, 60), $urandom_range(0, 2) == 0);
      drain_results();
    end
    eager_send = 1'b0;
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d event items over %0d register settings, including a %0d cycle",
             issued, phases, HOLD_CYCLES);
    $display("result stall, retry exhaustion bursts and %0d compared results.", checked);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/sws_pkg.sv
rtl/core/sws_ram.sv
rtl/core/sws_mod.sv
rtl/core/sliding_window_sender_core.sv
verif/sws_checker.sv
verif/tb_top.sv
